// ===== design/odo_pkg.sv =====
// shared types and constants for the differential drive odometry block
// holds fixed-point widths, cordic constants, payload structs and sequencer states
// no dependencies
package odo_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int POSE_WIDTH = 32;
  localparam int CFG_WIDTH  = 20;
  localparam int ADDR_WIDTH = 3;
  localparam int DATA_WIDTH = 32;

  // multiplier operands and product
  localparam int MUL_WIDTH  = POSE_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  // phase and x/y products are taken at this shift
  localparam int PH_LSB     = 30 + FRAC_BITS;
  localparam int ACC_WIDTH  = PH_LSB + POSE_WIDTH;
  localparam int PART_WIDTH = 32;
  localparam int M_WIDTH    = CFG_WIDTH + POSE_WIDTH;

  localparam int CORDIC_STEPS = 28;
  localparam int CNT_WIDTH    = 5;

  localparam logic [59:0] TURN_K = 60'd733972625820500311;
  localparam logic signed [POSE_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

  localparam logic [CFG_WIDTH-1:0] HALF_RADIUS_RST = 20'd43008;
  localparam logic [CFG_WIDTH-1:0] RADIUS_TRACK_RST = 20'd8995;

  // register indexes
  localparam logic REG_HALF_RADIUS  = 1'b0;
  localparam logic REG_RADIUS_TRACK = 1'b1;

  // wheel select
  localparam logic CMD_RIGHT = 1'b0;
  localparam logic CMD_LEFT  = 1'b1;

  // quadrant of the phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic                         cmd;
    logic signed [POSE_WIDTH-1:0] wheel_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [POSE_WIDTH-1:0] pose_x;
    logic signed [POSE_WIDTH-1:0] pose_y;
    logic signed [POSE_WIDTH-1:0] pose_heading;
    logic                         pose_updated;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PH0,
    ST_PH1,
    ST_CORD,
    ST_XA,
    ST_XL,
    ST_XH,
    ST_YA,
    ST_YL,
    ST_YH,
    ST_HD,
    ST_HW,
    ST_FIN
  } odo_state_e;

  typedef struct packed {
    logic acc_clr;
    logic acc_add;
    logic acc_hi;
    logic m_load;
    logic cord_init;
    logic cord_step;
    logic x_upd;
    logic y_upd;
    logic h_upd;
    logic out_load;
  } odo_ctrl_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic signed [POSE_WIDTH-1:0] atan_turn(input logic [CNT_WIDTH-1:0] idx);
    logic signed [POSE_WIDTH-1:0] v;
    case (idx)
      5'd0:    v = 32'sd536870912;
      5'd1:    v = 32'sd316933406;
      5'd2:    v = 32'sd167458907;
      5'd3:    v = 32'sd85004756;
      5'd4:    v = 32'sd42667331;
      5'd5:    v = 32'sd21354465;
      5'd6:    v = 32'sd10679838;
      5'd7:    v = 32'sd5340245;
      5'd8:    v = 32'sd2670163;
      5'd9:    v = 32'sd1335087;
      5'd10:   v = 32'sd667544;
      5'd11:   v = 32'sd333772;
      5'd12:   v = 32'sd166886;
      5'd13:   v = 32'sd83443;
      5'd14:   v = 32'sd41722;
      5'd15:   v = 32'sd20861;
      5'd16:   v = 32'sd10430;
      5'd17:   v = 32'sd5215;
      5'd18:   v = 32'sd2608;
      5'd19:   v = 32'sd1304;
      5'd20:   v = 32'sd652;
      5'd21:   v = 32'sd326;
      5'd22:   v = 32'sd163;
      5'd23:   v = 32'sd81;
      5'd24:   v = 32'sd41;
      5'd25:   v = 32'sd20;
      5'd26:   v = 32'sd10;
      5'd27:   v = 32'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/diff_drive_odometry.sv =====
// differential drive wheel odometry, top level
// one shared 33x33 multiplier and an iterative cordic under a small sequencer
// depends on odo_pkg
//
// usage:
//  - input channel (in_valid_i, in_stall_o, in_data_i) carries one wheel angle
//    transaction tagged right or left; the first sample of a wheel only primes it
//  - output channel (out_valid_o, out_stall_i, out_data_o) returns one pose
//    transaction per input: x, y, heading and a flag set when the pose advanced
//  - when both wheels hold a fresh step the pose is advanced: phase multiply
//    (ST_PH0, ST_PH1), 28 cordic iterations, multiply/accumulate for x, y and
//    heading (ST_XA to ST_HW), then the output register is loaded in ST_FIN;
//    the next transaction is taken once the sequencer is back in ST_IDLE
//  - an item that does not advance the pose goes straight to the output load
//  - the cordic iteration count and the single shared multiplier set the work
//  - in_stall_o is high while an item is in work; a finished result waits in the
//    output register while the next item is taken, and if the receiver still
//    stalls when that item is done the sequencer holds until the register frees
//  - reset clears pose, wheel history and loads the default geometry registers
//  - user must write geometry registers over apb port only while idle; unenforced
module diff_drive_odometry (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  odo_pkg::in_item_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output odo_pkg::out_item_t                out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [odo_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [odo_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [odo_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready
);
  import odo_pkg::*;

  odo_state_e state_q, state_d;
  odo_ctrl_t  ctrl;

  logic [CFG_WIDTH-1:0] half_radius_q, radius_track_q;

  logic signed [POSE_WIDTH-1:0] last_r_q, last_l_q, step_r_q, step_l_q;
  logic                         primed_r_q, primed_l_q, fresh_r_q, fresh_l_q;
  logic signed [POSE_WIDTH-1:0] pos_x_q, pos_y_q, heading_q;
  logic                         upd_q;

  logic signed [ACC_WIDTH-1:0]  acc_q, acc_d, addend;
  logic signed [M_WIDTH-1:0]    m_q;
  logic signed [POSE_WIDTH-1:0] cx_q, cy_q, cz_q;
  logic [1:0]                   quad_q;
  logic [CNT_WIDTH-1:0]         cnt_q;

  logic signed [MUL_WIDTH-1:0]  mul_a, mul_b, sum_w, diff_w;
  logic signed [PROD_WIDTH-1:0] prod;
  logic signed [POSE_WIDTH-1:0] cos_v, sin_v, xs, ys, atan_v;

  out_item_t out_q;
  logic      out_valid_q;

  logic in_acc, out_go, cfg_wr, both_fresh;

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_go = !out_valid_q || !out_stall_i;
  assign cfg_wr = psel && penable && pwrite && pready;

  // both wheels hold a fresh step once this transaction is applied
  assign both_fresh = ((in_data_i.cmd == CMD_RIGHT) ? primed_r_q : fresh_r_q) &&
                      ((in_data_i.cmd == CMD_LEFT)  ? primed_l_q : fresh_l_q);

  // configuration port
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      REG_HALF_RADIUS:  prdata = DATA_WIDTH'(half_radius_q);
      REG_RADIUS_TRACK: prdata = DATA_WIDTH'(radius_track_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_radius_q  <= HALF_RADIUS_RST;
      radius_track_q <= RADIUS_TRACK_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HALF_RADIUS) begin
        half_radius_q <= pwdata[CFG_WIDTH-1:0];
      end else begin
        radius_track_q <= pwdata[CFG_WIDTH-1:0];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = both_fresh ? ST_PH0 : ST_FIN;
        end
      end
      ST_PH0:  state_d = ST_PH1;
      ST_PH1:  state_d = ST_CORD;
      ST_CORD: begin
        if (cnt_q == CNT_WIDTH'(CORDIC_STEPS - 1)) begin
          state_d = ST_XA;
        end
      end
      ST_XA:   state_d = ST_XL;
      ST_XL:   state_d = ST_XH;
      ST_XH:   state_d = ST_YA;
      ST_YA:   state_d = ST_YL;
      ST_YL:   state_d = ST_YH;
      ST_YH:   state_d = ST_HD;
      ST_HD:   state_d = ST_HW;
      ST_HW:   state_d = ST_FIN;
      ST_FIN: begin
        if (out_go) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // wheel sum and difference, exact at one extra bit
  assign sum_w  = {step_r_q[POSE_WIDTH-1], step_r_q} + {step_l_q[POSE_WIDTH-1], step_l_q};
  assign diff_w = {step_r_q[POSE_WIDTH-1], step_r_q} - {step_l_q[POSE_WIDTH-1], step_l_q};

  // quadrant turn of the cordic vector
  always_comb begin
    case (quad_q)
      QUAD_0: begin cos_v = cx_q;  sin_v = cy_q;  end
      QUAD_1: begin cos_v = -cy_q; sin_v = cx_q;  end
      QUAD_2: begin cos_v = -cx_q; sin_v = -cy_q; end
      QUAD_3: begin cos_v = cy_q;  sin_v = -cx_q; end
      default: begin cos_v = cx_q; sin_v = cy_q;  end
    endcase
  end

  // sequencer outputs and multiplier operand select
  always_comb begin
    ctrl  = '0;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PH0: begin
        ctrl.acc_clr = 1'b1;
        mul_a = {heading_q[POSE_WIDTH-1], heading_q};
        mul_b = {1'b0, TURN_K[31:0]};
      end
      ST_PH1: begin
        ctrl.acc_add   = 1'b1;
        ctrl.acc_hi    = 1'b1;
        ctrl.cord_init = 1'b1;
        mul_a = {heading_q[POSE_WIDTH-1], heading_q};
        mul_b = MUL_WIDTH'(TURN_K[59:32]);
      end
      ST_CORD: ctrl.cord_step = 1'b1;
      ST_XA, ST_YA: begin
        ctrl.m_load = 1'b1;
        ctrl.x_upd  = (state_q == ST_YA);
        mul_a = MUL_WIDTH'(half_radius_q);
        mul_b = (state_q == ST_XA) ? {cos_v[POSE_WIDTH-1], cos_v}
                                   : {sin_v[POSE_WIDTH-1], sin_v};
      end
      ST_XL, ST_YL: begin
        ctrl.acc_clr = 1'b1;
        mul_a = sum_w;
        mul_b = {1'b0, m_q[PART_WIDTH-1:0]};
      end
      ST_XH, ST_YH: begin
        ctrl.acc_add = 1'b1;
        ctrl.acc_hi  = 1'b1;
        mul_a = sum_w;
        mul_b = {{(MUL_WIDTH-CFG_WIDTH){m_q[M_WIDTH-1]}}, m_q[M_WIDTH-1:PART_WIDTH]};
      end
      ST_HD: begin
        ctrl.acc_clr = 1'b1;
        ctrl.y_upd   = 1'b1;
        mul_a = diff_w;
        mul_b = MUL_WIDTH'(radius_track_q);
      end
      ST_HW: ctrl.h_upd = 1'b1;
      ST_FIN: ctrl.out_load = out_go;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // shared multiplier and accumulator
  assign prod   = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);
  assign addend = {{(ACC_WIDTH-PROD_WIDTH){prod[PROD_WIDTH-1]}}, prod};

  always_comb begin
    acc_d = acc_q;
    if (ctrl.acc_clr) begin
      acc_d = addend;
    end else if (ctrl.acc_add) begin
      acc_d = acc_q + (ctrl.acc_hi ? (addend <<< PART_WIDTH) : addend);
    end
  end

  // one cordic micro-rotation per cycle
  assign xs     = cx_q >>> cnt_q;
  assign ys     = cy_q >>> cnt_q;
  assign atan_v = atan_turn(cnt_q);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (ctrl.m_load) begin
      m_q <= prod[M_WIDTH-1:0];
    end
    if (ctrl.cord_init) begin
      cx_q   <= CORDIC_GAIN;
      cy_q   <= '0;
      cz_q   <= signed'({2'b00, acc_d[PH_LSB+29:PH_LSB]});
      quad_q <= acc_d[PH_LSB+31:PH_LSB+30];
      cnt_q  <= '0;
    end else if (ctrl.cord_step) begin
      if (!cz_q[POSE_WIDTH-1]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atan_v;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atan_v;
      end
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctrl.out_load) begin
      out_q.pose_x       <= pos_x_q;
      out_q.pose_y       <= pos_y_q;
      out_q.pose_heading <= heading_q;
      out_q.pose_updated <= upd_q;
    end
  end

  // sequencer, wheel history, pose and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_r_q    <= '0;
      last_l_q    <= '0;
      step_r_q    <= '0;
      step_l_q    <= '0;
      primed_r_q  <= 1'b0;
      primed_l_q  <= 1'b0;
      fresh_r_q   <= 1'b0;
      fresh_l_q   <= 1'b0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      heading_q   <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        if (in_data_i.cmd == CMD_RIGHT) begin
          if (primed_r_q) begin
            step_r_q  <= in_data_i.wheel_angle - last_r_q;
            fresh_r_q <= !both_fresh;
          end
          primed_r_q <= 1'b1;
          last_r_q   <= in_data_i.wheel_angle;
          if (both_fresh) begin
            fresh_l_q <= 1'b0;
          end
        end else begin
          if (primed_l_q) begin
            step_l_q  <= in_data_i.wheel_angle - last_l_q;
            fresh_l_q <= !both_fresh;
          end
          primed_l_q <= 1'b1;
          last_l_q   <= in_data_i.wheel_angle;
          if (both_fresh) begin
            fresh_r_q <= 1'b0;
          end
        end
        upd_q <= both_fresh;
      end
      if (ctrl.x_upd) begin
        pos_x_q <= pos_x_q + acc_q[PH_LSB+POSE_WIDTH-1:PH_LSB];
      end
      if (ctrl.y_upd) begin
        pos_y_q <= pos_y_q + acc_q[PH_LSB+POSE_WIDTH-1:PH_LSB];
      end
      if (ctrl.h_upd) begin
        heading_q <= heading_q + acc_q[FRAC_BITS+POSE_WIDTH-1:FRAC_BITS];
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
